/* design/mbup_pkg.sv */
`default_nettype none

package mbup_pkg;

  localparam logic [3:0] KIND_PROG  = 4'hC;
  localparam logic [3:0] KIND_PRESS = 4'hD;
  localparam logic [3:0] KIND_SYS   = 4'hF;

  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_SONG_POS = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL = 8'hF3;
  localparam logic [7:0] ST_EOX      = 8'hF7;
  localparam logic [7:0] ST_CLOCK    = 8'hF8;
  localparam logic [7:0] ST_START    = 8'hFA;
  localparam logic [7:0] ST_CONT     = 8'hFB;
  localparam logic [7:0] ST_STOP     = 8'hFC;
  localparam logic [7:0] ST_SENSE    = 8'hFE;
  localparam logic [7:0] ST_RESET    = 8'hFF;

  localparam logic [3:0] CIN_COMMON2 = 4'd2;
  localparam logic [3:0] CIN_COMMON3 = 4'd3;
  localparam logic [3:0] CIN_SYSEX   = 4'd4;
  localparam logic [3:0] CIN_SINGLE  = 4'd5;
  localparam logic [3:0] CIN_END2    = 4'd6;
  localparam logic [3:0] CIN_END3    = 4'd7;

  typedef struct packed {
    logic [3:0] code_index;
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] third;
  } pkt_t;

endpackage

`default_nettype wire

/* design/mbup_in_reg.sv */
`default_nettype none

module mbup_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] midi_byte,
  input  logic       adv,
  output logic       vld,
  output logic [7:0] data
);

  assign in_stall = vld && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (!in_stall) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      data <= midi_byte;
    end
  end

endmodule

`default_nettype wire

/* design/mbup_packer.sv */
`default_nettype none

module mbup_packer (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic [7:0]    byte_in,
  output logic          emit,
  output mbup_pkg::pkt_t pkt
);
  import mbup_pkg::*;

  typedef struct packed {
    logic       armed;
    logic [1:0] len;
    logic [1:0] cnt;
    logic       excl;
    logic [3:0] cin;
    logic [7:0] p0;
    logic [7:0] p1;
    logic [7:0] p2;
  } state_t;

  state_t st;
  state_t st_next;
  state_t s;

  function automatic state_t start_msg(input logic [3:0] cin, input logic [1:0] len,
                                       input logic [7:0] first, input logic excl);
    state_t r;
    r.armed = 1'b1;
    r.len   = len;
    r.cnt   = 2'd1;
    r.excl  = excl;
    r.cin   = cin;
    r.p0    = first;
    r.p1    = 8'd0;
    r.p2    = 8'd0;
    return r;
  endfunction

  always_comb begin
    s = st;
    if (byte_in[7]) begin
      if (byte_in[7:4] != KIND_SYS) begin
        s = start_msg(byte_in[7:4],
                      (byte_in[7:4] == KIND_PROG || byte_in[7:4] == KIND_PRESS) ? 2'd2 : 2'd3,
                      byte_in, 1'b0);
      end else begin
        unique case (byte_in) inside
          ST_SONG_POS: s = start_msg(CIN_COMMON3, 2'd3, byte_in, 1'b0);
          ST_SONG_SEL: s = start_msg(CIN_COMMON2, 2'd2, byte_in, 1'b0);
          ST_SYSEX:    s = start_msg(CIN_SYSEX, 2'd3, byte_in, 1'b1);
          ST_CLOCK:    s = start_msg(CIN_SINGLE, 2'd1, byte_in, 1'b0);
          ST_START, ST_CONT, ST_STOP, ST_SENSE, ST_RESET: begin
            s = start_msg(CIN_SINGLE, 2'd1, byte_in, st.excl);
          end
          ST_EOX: begin
            s.armed = 1'b1;
            s.excl  = 1'b0;
            if (st.cnt == 2'd1) begin
              s.len = 2'd2;
              s.cnt = 2'd2;
              s.cin = CIN_END2;
              s.p1  = byte_in;
              s.p2  = 8'd0;
            end else if (st.cnt == 2'd2) begin
              s.len = 2'd3;
              s.cnt = 2'd3;
              s.cin = CIN_END3;
              s.p2  = byte_in;
            end else begin
              s.len = 2'd1;
              s.cnt = 2'd1;
              s.cin = CIN_SINGLE;
              s.p0  = byte_in;
              s.p1  = 8'd0;
              s.p2  = 8'd0;
            end
          end
          default: begin
            s.armed = 1'b0;
            s.len   = 2'd0;
            s.cnt   = 2'd0;
            s.excl  = 1'b0;
          end
        endcase
      end
    end else if (st.armed && st.cnt != 2'd3) begin
      case (st.cnt)
        2'd0:    s.p0 = byte_in;
        2'd1:    s.p1 = byte_in;
        default: s.p2 = byte_in;
      endcase
      s.cnt = st.cnt + 2'd1;
    end

    emit = s.armed && (s.cnt == s.len);
    pkt.code_index = s.cin;
    pkt.first      = s.p0;
    pkt.second     = s.p1;
    pkt.third      = s.p2;

    st_next = s;
    if (emit) begin
      if (s.excl) begin
        st_next.len = 2'd3;
        st_next.cnt = 2'd0;
        st_next.cin = CIN_SYSEX;
      end else begin
        st_next.armed = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (adv) begin
      st <= st_next;
    end
  end

`ifndef SYNTH
  a_armed_len : assert property (@(posedge clk) disable iff (rst)
    st.armed |-> st.len != 2'd0)
    else $error("armed with zero length");
  a_excl_armed : assert property (@(posedge clk) disable iff (rst)
    st.excl |-> st.armed)
    else $error("exclusive flag without armed");
  a_disarm : assert property (@(posedge clk) disable iff (rst)
    adv && emit && !s.excl |=> !st.armed)
    else $error("packer still armed after a closing packet");
`endif

endmodule

`default_nettype wire

/* design/mbup_out_reg.sv */
`default_nettype none

module mbup_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  mbup_pkg::pkt_t pkt,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [3:0]     code_index,
  output logic [7:0]     payload_first,
  output logic [7:0]     payload_second,
  output logic [7:0]     payload_third
);
  import mbup_pkg::*;

  pkt_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= pkt;
    end
  end

  assign code_index     = held.code_index;
  assign payload_first  = held.first;
  assign payload_second = held.second;
  assign payload_third  = held.third;

`ifndef SYNTH
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !load)
    else $error("pending packet overwritten");
`endif

endmodule

`default_nettype wire

/* design/midi_byte_to_usb_event_packer.sv */
`default_nettype none

// Packs a stream of MIDI bytes into USB-MIDI event packets. One byte is taken per
// clock while in_stall is low; a byte that completes a message appears as a packet
// once it has passed the input register and then the combinational state update
// that loads the result register. Bytes that complete nothing yield no packet. A
// packet waiting under out_stall holds the pipeline, so in_stall rises only when
// both registers are full.
module midi_byte_to_usb_event_packer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] midi_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] code_index,
  output logic [7:0] payload_first,
  output logic [7:0] payload_second,
  output logic [7:0] payload_third
);
  import mbup_pkg::*;

  logic       adv;
  logic       stage_vld;
  logic [7:0] stage_byte;
  logic       emit;
  pkt_t       pkt;

  assign adv = stage_vld && (!out_valid || !out_stall);

  mbup_in_reg u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .midi_byte (midi_byte),
    .adv       (adv),
    .vld       (stage_vld),
    .data      (stage_byte)
  );

  mbup_packer u_packer (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .byte_in (stage_byte),
    .emit    (emit),
    .pkt     (pkt)
  );

  mbup_out_reg u_out (
    .clk            (clk),
    .rst            (rst),
    .load           (adv && emit),
    .pkt            (pkt),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .code_index     (code_index),
    .payload_first  (payload_first),
    .payload_second (payload_second),
    .payload_third  (payload_third)
  );

`ifndef SYNTH
  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> stage_vld && out_valid && out_stall)
    else $error("input stalled with room downstream");
`endif

endmodule

`default_nettype wire

/* test/midi_byte_to_usb_event_packer_tb.sv */
`timescale 1ns / 100ps

module midi_byte_to_usb_event_packer_tb;
  import mbup_pkg::*;

  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_BEND     = 4'hE;

  localparam logic [7:0] ST_MTC_QF  = 8'hF1;
  localparam logic [7:0] ST_UNDEF_A = 8'hF4;
  localparam logic [7:0] ST_UNDEF_B = 8'hF5;
  localparam logic [7:0] ST_TUNE    = 8'hF6;
  localparam logic [7:0] ST_UNDEF_C = 8'hF9;
  localparam logic [7:0] ST_UNDEF_D = 8'hFD;

  localparam int MAX_GAP      = 13;
  localparam int HOLD_CYCLES  = 150;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 10;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [7:0] midi_byte;
  logic out_valid;
  logic out_stall;
  logic [3:0] code_index;
  logic [7:0] payload_first;
  logic [7:0] payload_second;
  logic [7:0] payload_third;

  midi_byte_to_usb_event_packer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .midi_byte(midi_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .code_index(code_index),
    .payload_first(payload_first),
    .payload_second(payload_second),
    .payload_third(payload_third)
  );

  logic [7:0] realtime_codes[6] = '{ST_CLOCK, ST_START, ST_CONT, ST_STOP, ST_SENSE, ST_RESET};
  logic [7:0] unsupported_codes[6] =
    '{ST_MTC_QF, ST_UNDEF_A, ST_UNDEF_B, ST_TUNE, ST_UNDEF_C, ST_UNDEF_D};

  // packer state
  bit armed;
  logic [1:0] msg_len;
  logic [1:0] byte_cnt;
  bit in_sysex;
  logic [3:0] held_cin;
  logic [7:0] held[3];

  pkt_t pending_pkts[$];
  pkt_t want;
  int mismatch_count;
  int beats_sent;
  int idle_cycles;
  int rx_wait;
  bit tx_idle;
  bit rx_idle;
  bit hold_rx;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void reset_packer();
    armed = 1'b0;
    msg_len = 2'd0;
    byte_cnt = 2'd0;
    in_sysex = 1'b0;
    held_cin = 4'd0;
    held[0] = 8'd0;
    held[1] = 8'd0;
    held[2] = 8'd0;
  endfunction

  function automatic void open_message(logic [3:0] cin, logic [1:0] len, logic [7:0] first,
                                       bit sysex);
    armed = 1'b1;
    msg_len = len;
    byte_cnt = 2'd1;
    in_sysex = sysex;
    held_cin = cin;
    held[0] = first;
    held[1] = 8'd0;
    held[2] = 8'd0;
  endfunction

  function automatic bit advance_packer(input logic [7:0] b, output pkt_t pkt);
    logic [3:0] kind;
    kind = b[7:4];
    pkt = '0;
    if (b[7]) begin
      if (kind != KIND_SYS) begin
        open_message(kind, (kind == KIND_PROG || kind == KIND_PRESS) ? 2'd2 : 2'd3, b, 1'b0);
      end else begin
        case (b)
          ST_SONG_POS: open_message(CIN_COMMON3, 2'd3, b, 1'b0);
          ST_SONG_SEL: open_message(CIN_COMMON2, 2'd2, b, 1'b0);
          ST_SYSEX:    open_message(CIN_SYSEX, 2'd3, b, 1'b1);
          ST_CLOCK:    open_message(CIN_SINGLE, 2'd1, b, 1'b0);
          ST_START, ST_CONT, ST_STOP, ST_SENSE, ST_RESET: begin
            open_message(CIN_SINGLE, 2'd1, b, in_sysex);
          end
          ST_EOX: begin
            armed = 1'b1;
            if (byte_cnt == 2'd1) begin
              msg_len = 2'd2;
              byte_cnt = 2'd2;
              held_cin = CIN_END2;
              held[1] = b;
              held[2] = 8'd0;
            end else if (byte_cnt == 2'd2) begin
              msg_len = 2'd3;
              byte_cnt = 2'd3;
              held_cin = CIN_END3;
              held[2] = b;
            end else begin
              msg_len = 2'd1;
              byte_cnt = 2'd1;
              held_cin = CIN_SINGLE;
              held[0] = b;
              held[1] = 8'd0;
              held[2] = 8'd0;
            end
            in_sysex = 1'b0;
          end
          default: begin
            armed = 1'b0;
            msg_len = 2'd0;
            byte_cnt = 2'd0;
            in_sysex = 1'b0;
          end
        endcase
      end
    end else if (armed && byte_cnt < 2'd3) begin
      held[byte_cnt] = b;
      byte_cnt = byte_cnt + 2'd1;
    end
    if (armed && byte_cnt == msg_len) begin
      pkt.code_index = held_cin;
      pkt.first = held[0];
      pkt.second = held[1];
      pkt.third = held[2];
      if (in_sysex) begin
        msg_len = 2'd3;
        byte_cnt = 2'd0;
        held_cin = CIN_SYSEX;
      end else begin
        armed = 1'b0;
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    pkt_t pkt;
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    midi_byte <= b;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    if (advance_packer(b, pkt)) pending_pkts.push_back(pkt);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pkts.size() != 0) @(posedge clk);
  endtask

  task automatic send_channel_message();
    logic [3:0] kind;
    kind = 4'($urandom_range(KIND_NOTE_OFF, KIND_BEND));
    send_byte({kind, 4'($urandom_range(0, 15))});
    send_byte(8'($urandom_range(0, 127)));
    if (kind != KIND_PROG && kind != KIND_PRESS) send_byte(8'($urandom_range(0, 127)));
  endtask

  task automatic test_dropped_data();
    send_byte(8'h00);
    send_byte(8'h7F);
  endtask

  task automatic test_channel_messages();
    send_byte({KIND_NOTE_ON, 4'hF});
    send_byte(8'h7F);
    send_byte(8'h00);
    send_byte({KIND_PROG, 4'h0});
    send_byte(8'h55);
  endtask

  task automatic test_system_common();
    send_byte(ST_SONG_POS);
    send_byte(8'h01);
    send_byte(8'h7F);
    send_byte(ST_SONG_SEL);
    send_byte(8'h10);
  endtask

  task automatic test_stale_eox();
    send_byte(ST_EOX);
  endtask

  task automatic test_realtime();
    send_byte(ST_RESET);
    send_byte(ST_CLOCK);
  endtask

  task automatic test_sysex();
    send_byte(ST_SYSEX);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h03);
    send_byte(ST_EOX);
    send_byte(ST_SYSEX);
    send_byte(ST_SENSE);
    send_byte(8'h2A);
    send_byte(ST_EOX);
    send_byte(ST_SYSEX);
    send_byte(ST_CLOCK);
  endtask

  task automatic test_unsupported_status();
    send_byte(ST_TUNE);
    send_byte(8'h40);
  endtask

  task automatic test_output_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;
    hold_rx = 1'b1;
    fork
      begin
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end
    join_none
    repeat (8) send_channel_message();
    wait_drained();
  endtask

  task automatic test_random_traffic(input int count, input bit tx_gaps, input bit rx_gaps);
    int target;
    int pick;
    int len;
    tx_idle = tx_gaps;
    rx_idle = rx_gaps;
    target = beats_sent + count;
    while (beats_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_channel_message();
      end else if (pick < 55) begin
        if ($urandom_range(0, 1)) begin
          send_byte(ST_SONG_POS);
          send_byte(8'($urandom_range(0, 127)));
          send_byte(8'($urandom_range(0, 127)));
        end else begin
          send_byte(ST_SONG_SEL);
          send_byte(8'($urandom_range(0, 127)));
        end
      end else if (pick < 65) begin
        send_byte(realtime_codes[3'($urandom_range(0, 5))]);
      end else if (pick < 85) begin
        send_byte(ST_SYSEX);
        len = $urandom_range(0, 9);
        repeat (len) begin
          if ($urandom_range(0, 9) == 0) send_byte(realtime_codes[3'($urandom_range(0, 5))]);
          send_byte(8'($urandom_range(0, 127)));
        end
        send_byte(ST_EOX);
      end else if (pick < 90) begin
        send_byte(unsupported_codes[3'($urandom_range(0, 5))]);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  function automatic void check_field(string name, logic [7:0] expected, logic [7:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %0h, got %0h", name, expected, actual);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_pkts.size() == 0) begin
        $error("packet with none pending: cin %0h bytes %0h %0h %0h",
               code_index, payload_first, payload_second, payload_third);
        mismatch_count++;
      end else begin
        want = pending_pkts.pop_front();
        check_field("code_index", {4'd0, want.code_index}, {4'd0, code_index});
        check_field("payload_first", want.first, payload_first);
        check_field("payload_second", want.second, payload_second);
        check_field("payload_third", want.third, payload_third);
      end
      rx_wait = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= hold_rx || rx_wait > 0;
      if (rx_wait > 0) rx_wait--;
    end
  end

  initial begin
    idle_cycles = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    midi_byte = 8'd0;
    hold_rx = 1'b0;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_wait = 0;
    mismatch_count = 0;
    beats_sent = 0;
    reset_packer();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_dropped_data();
    test_channel_messages();
    test_system_common();
    test_stale_eox();
    test_realtime();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    test_sysex();
    test_unsupported_status();
    test_output_backpressure();
    test_random_traffic(400, 1'b1, 1'b1);
    test_random_traffic(200, 1'b0, 1'b0);
    test_random_traffic(200, 1'b1, 1'b0);
    test_random_traffic(200, 1'b0, 1'b1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_pkts.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
